// File: hdl/iflr_pkg.sv
// shared types and codes for the ipv4 first-match route lookup
package iflr_pkg;

   localparam int ENTRY_INDEX_W = 4;
   localparam int IFACE_W       = 4;
   localparam int ADDR_W        = 32;
   localparam int STATUS_W      = 3;
   localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      REQ_WR_ROUTE  = 2'd0,
      REQ_WR_SUBNET = 2'd1,
      REQ_LOOKUP    = 2'd2,
      REQ_BCAST     = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_WRITE   = 3'd0,
      ST_ROUTE   = 3'd1,
      ST_SUBNET  = 3'd2,
      ST_GATEWAY = 3'd3,
      ST_BCAST   = 3'd4,
      ST_NONE    = 3'd5
   } status_type;

   // request travelling down the cell row
   typedef struct packed {
      logic                     valid;
      req_kind_type             kind;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [ADDR_W-1:0]        dest_ip;
      logic [ADDR_W-1:0]        net_addr;
      logic [ADDR_W-1:0]        net_mask;
      logic [ADDR_W-1:0]        gateway_ip;
      logic [IFACE_W-1:0]       iface_id;
      logic                     entry_valid;
      logic                     use_iface;
   } token_type;

   // partial answer gathered along the row
   typedef struct packed {
      logic                     route_hit;
      logic [ENTRY_INDEX_W-1:0] route_idx;
      logic [IFACE_W-1:0]       route_iface;
      logic                     subnet_hit;
      logic [ENTRY_INDEX_W-1:0] subnet_idx;
      logic [IFACE_W-1:0]       subnet_iface;
      logic                     gw_hit;
      logic [ENTRY_INDEX_W-1:0] gw_idx;
      logic [IFACE_W-1:0]       gw_iface;
      logic [ADDR_W-1:0]        gw_ip;
      logic                     bc_hit;
      logic [ADDR_W-1:0]        bc_ip;
   } acc_type;

endpackage

// File: hdl/iflr_cell.sv
// one cell of the row: one route entry, one subnet entry and a pipeline stage
module iflr_cell #(
   parameter int CELL_INDEX = 0,
   parameter bit ROUTE_EN   = 1'b1,
   parameter bit SUBNET_EN  = 1'b1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  iflr_pkg::token_type up_tok,
   input  iflr_pkg::acc_type   up_acc,
   output iflr_pkg::token_type dn_tok,
   output iflr_pkg::acc_type   dn_acc
);

   localparam int IW = iflr_pkg::ENTRY_INDEX_W;
   localparam int AW = iflr_pkg::ADDR_W;
   localparam int FW = iflr_pkg::IFACE_W;
   localparam bit INDEX_REACHABLE = (CELL_INDEX < (1 << IW));
   localparam logic [IW-1:0] CELL_CODE = IW'(CELL_INDEX);

   logic          r_valid_ff;
   logic [AW-1:0] r_addr_ff;
   logic [AW-1:0] r_mask_ff;
   logic [FW-1:0] r_iface_ff;
   logic          s_valid_ff;
   logic [AW-1:0] s_addr_ff;
   logic [AW-1:0] s_mask_ff;
   logic [AW-1:0] s_gw_ff;
   logic [FW-1:0] s_iface_ff;

   iflr_pkg::token_type tok_ff;
   iflr_pkg::acc_type   acc_ff;
   iflr_pkg::acc_type   acc_in;

   logic sel;
   logic wr_route;
   logic wr_subnet;
   logic r_match;
   logic s_match;

   assign sel       = up_tok.valid && INDEX_REACHABLE && (up_tok.entry_index == CELL_CODE);
   assign wr_route  = advance && sel && ROUTE_EN && (up_tok.kind == iflr_pkg::REQ_WR_ROUTE);
   assign wr_subnet = advance && sel && SUBNET_EN && (up_tok.kind == iflr_pkg::REQ_WR_SUBNET);

   assign r_match = r_valid_ff && (((up_tok.dest_ip ^ r_addr_ff) & r_mask_ff) == '0);
   assign s_match = s_valid_ff && (((up_tok.dest_ip ^ s_addr_ff) & s_mask_ff) == '0);

   always_comb begin
      acc_in = up_acc;
      if (!up_acc.route_hit && r_match) begin
         acc_in.route_hit   = 1'b1;
         acc_in.route_idx   = CELL_CODE;
         acc_in.route_iface = r_iface_ff;
      end
      if (!up_acc.subnet_hit && s_match) begin
         acc_in.subnet_hit   = 1'b1;
         acc_in.subnet_idx   = CELL_CODE;
         acc_in.subnet_iface = s_iface_ff;
      end
      if (!up_acc.gw_hit && s_valid_ff && (s_gw_ff != '0)) begin
         acc_in.gw_hit   = 1'b1;
         acc_in.gw_idx   = CELL_CODE;
         acc_in.gw_iface = s_iface_ff;
         acc_in.gw_ip    = s_gw_ff;
      end
      if (sel && s_valid_ff) begin
         acc_in.bc_hit = 1'b1;
         acc_in.bc_ip  = s_addr_ff | ~s_mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         tok_ff     <= '0;
      end else begin
         if (wr_route) begin
            r_valid_ff <= up_tok.entry_valid;
         end
         if (wr_subnet) begin
            s_valid_ff <= up_tok.entry_valid;
         end
         if (advance) begin
            tok_ff <= up_tok;
         end
      end
   end

   // entry payload, only read behind its valid bit, and the stage's answer register
   always_ff @(posedge clock) begin
      if (wr_route) begin
         r_addr_ff  <= up_tok.net_addr;
         r_mask_ff  <= up_tok.net_mask;
         r_iface_ff <= up_tok.iface_id;
      end
      if (wr_subnet) begin
         s_addr_ff  <= up_tok.net_addr;
         s_mask_ff  <= up_tok.net_mask;
         s_gw_ff    <= up_tok.gateway_ip;
         s_iface_ff <= up_tok.iface_id;
      end
      if (advance) begin
         acc_ff <= acc_in;
      end
   end

   assign dn_tok = tok_ff;
   assign dn_acc = acc_ff;

endmodule

// File: hdl/ipv4_first_match_route_lookup.sv
// top level: ipv4 first-match route lookup over a row of table cells
// path: a request passes through the stage register of every cell in the row, then the
//   output register, before its result is offered
// throughput: one transaction per cycle; the whole row steps together and holds while the
//   output register is full and not taken
// reset: synchronous, clears every route and subnet valid bit and empties the row and output
module ipv4_first_match_route_lookup #(
   parameter int ROUTE_ENTRIES  = 16,
   parameter int SUBNET_ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // entry_index[3:0], dest_ip[35:4], net_addr[67:36], net_mask[99:68],
   // gateway_ip[131:100], iface_id[135:132], entry_valid[136], use_iface[137], zero pad
   input  logic [143:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // match_index[3:0], out_iface[7:4], next_hop_ip[39:8]
   output logic [39:0]  rsp_tdata,
   // status[2:0]
   output logic [2:0]   rsp_tuser
);

   localparam int CELLS = (ROUTE_ENTRIES > SUBNET_ENTRIES) ? ROUTE_ENTRIES : SUBNET_ENTRIES;
   localparam int IW = iflr_pkg::ENTRY_INDEX_W;
   localparam int AW = iflr_pkg::ADDR_W;
   localparam int FW = iflr_pkg::IFACE_W;

   // links between cells, link 0 is the request, link CELLS the last stage
   iflr_pkg::token_type tok_link [CELLS+1];
   iflr_pkg::acc_type   acc_link [CELLS+1];

   logic advance;

   // output register
   logic                 out_valid_ff;
   iflr_pkg::status_type out_status_ff;
   logic [IW-1:0]        out_index_ff;
   logic [FW-1:0]        out_iface_ff;
   logic [AW-1:0]        out_hop_ff;

   iflr_pkg::status_type out_status_in;
   logic [IW-1:0]        out_index_in;
   logic [FW-1:0]        out_iface_in;
   logic [AW-1:0]        out_hop_in;

   iflr_pkg::token_type last_tok;
   iflr_pkg::acc_type   last_acc;

   // the row moves whenever the output register can take what leaves it
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   // unpack the request transaction
   always_comb begin
      tok_link[0]             = '0;
      tok_link[0].valid       = req_tvalid;
      tok_link[0].kind        = iflr_pkg::req_kind_type'(req_tuser);
      tok_link[0].entry_index = req_tdata[3:0];
      tok_link[0].dest_ip     = req_tdata[35:4];
      tok_link[0].net_addr    = req_tdata[67:36];
      tok_link[0].net_mask    = req_tdata[99:68];
      tok_link[0].gateway_ip  = req_tdata[131:100];
      tok_link[0].iface_id    = req_tdata[135:132];
      tok_link[0].entry_valid = req_tdata[136];
      tok_link[0].use_iface   = req_tdata[137];
   end

   assign acc_link[0] = '0;

   // cell g holds route entry g and subnet entry g where those exist
   for (genvar g = 0; g < CELLS; g++) begin : gen_cell
      iflr_cell #(
         .CELL_INDEX (g),
         .ROUTE_EN   (g < ROUTE_ENTRIES),
         .SUBNET_EN  (g < SUBNET_ENTRIES)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_tok  (tok_link[g]),
         .up_acc  (acc_link[g]),
         .dn_tok  (tok_link[g+1]),
         .dn_acc  (acc_link[g+1])
      );
   end

   assign last_tok = tok_link[CELLS];
   assign last_acc = acc_link[CELLS];

   // final priority: route table, then subnet table, then the gateway subnet
   always_comb begin
      out_status_in = iflr_pkg::ST_WRITE;
      out_index_in  = '0;
      out_iface_in  = '0;
      out_hop_in    = '0;
      case (last_tok.kind)
         iflr_pkg::REQ_LOOKUP: begin
            if (last_acc.route_hit) begin
               out_status_in = iflr_pkg::ST_ROUTE;
               out_index_in  = last_acc.route_idx;
               out_iface_in  = last_acc.route_iface;
               out_hop_in    = last_tok.dest_ip;
            end else if (last_acc.subnet_hit) begin
               out_status_in = iflr_pkg::ST_SUBNET;
               out_index_in  = last_acc.subnet_idx;
               out_iface_in  = last_acc.subnet_iface;
               out_hop_in    = last_tok.dest_ip;
            end else if (last_acc.gw_hit) begin
               out_status_in = iflr_pkg::ST_GATEWAY;
               out_index_in  = last_acc.gw_idx;
               out_iface_in  = last_acc.gw_iface;
               out_hop_in    = last_acc.gw_ip;
            end else begin
               out_status_in = iflr_pkg::ST_NONE;
            end
         end
         iflr_pkg::REQ_BCAST: begin
            if (last_tok.use_iface) begin
               // directed broadcast of the named subnet, limited broadcast otherwise
               out_status_in = iflr_pkg::ST_BCAST;
               out_iface_in  = last_tok.iface_id;
               if (last_acc.bc_hit) begin
                  out_index_in = last_tok.entry_index;
                  out_hop_in   = last_acc.bc_ip;
               end else begin
                  out_hop_in   = iflr_pkg::ALL_ONES;
               end
            end else if (last_acc.gw_hit) begin
               out_status_in = iflr_pkg::ST_BCAST;
               out_index_in  = last_acc.gw_idx;
               out_iface_in  = last_acc.gw_iface;
               out_hop_in    = iflr_pkg::ALL_ONES;
            end else begin
               out_status_in = iflr_pkg::ST_NONE;
            end
         end
         default: begin
            // table writes answer with an all-zero result
            out_status_in = iflr_pkg::ST_WRITE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= last_tok.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && last_tok.valid) begin
         out_status_ff <= out_status_in;
         out_index_ff  <= out_index_in;
         out_iface_ff  <= out_iface_in;
         out_hop_ff    <= out_hop_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {out_hop_ff, out_iface_ff, out_index_ff};

   // write transactions answer with nothing but the status
   a_write_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_status_ff == iflr_pkg::ST_WRITE)) |-> (rsp_tdata == '0))
      else $error("write response carries nonzero data");

   // no route answers carry no entry, interface or next hop
   a_none_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_status_ff == iflr_pkg::ST_NONE)) |-> (rsp_tdata == '0))
      else $error("no-route response carries nonzero data");

   // a stalled row keeps its last stage in place
   a_row_hold : assert property (@(posedge clock) disable iff (reset)
      (last_tok.valid && !advance) |=> (last_tok.valid && $stable(last_tok)))
      else $error("last cell stage changed while stalled");

   // reset empties the output register
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

// File: dv/route_lookup_checker.sv
// checker for the route lookup: watches both channels, predicts each response and compares
module route_lookup_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [143:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   output int           fail_count,
   output int           pending,
   output int           checked,
   output logic [5:0]   status_seen
);

   localparam int ROUTES  = 16;
   localparam int SUBNETS = 16;

   typedef struct packed {
      iflr_pkg::req_kind_type kind;
      logic [3:0]             index;
      logic [31:0]            dest;
      logic [31:0]            addr;
      logic [31:0]            mask;
      logic [31:0]            gw;
      logic [3:0]             iface;
      logic                   entry_valid;
      logic                   use_iface;
   } route_req_type;

   typedef struct packed {
      iflr_pkg::status_type status;
      logic [3:0]           match_index;
      logic [3:0]           out_iface;
      logic [31:0]          next_hop;
   } route_answer_type;

   route_answer_type expected_answers[$];

   logic        rt_valid[ROUTES];
   logic [31:0] rt_addr[ROUTES];
   logic [31:0] rt_mask[ROUTES];
   logic [3:0]  rt_iface[ROUTES];
   logic        sn_valid[SUBNETS];
   logic [31:0] sn_addr[SUBNETS];
   logic [31:0] sn_mask[SUBNETS];
   logic [31:0] sn_gw[SUBNETS];
   logic [3:0]  sn_iface[SUBNETS];

   int          fails = 0;
   int          seen_rsp = 0;
   logic [5:0]  seen_mask = '0;

   // lowest valid subnet with a gateway, -1 if none
   function automatic int first_gateway_subnet();
      int i;
      int g;
      g = -1;
      for (i = SUBNETS - 1; i >= 0; i--)
         if (sn_valid[i] && sn_gw[i] != 32'd0) g = i;
      return g;
   endfunction

   function automatic route_answer_type predict_answer(input route_req_type r);
      route_answer_type a;
      int               i;
      int               hit;
      int               g;
      a.status      = iflr_pkg::ST_WRITE;
      a.match_index = '0;
      a.out_iface   = '0;
      a.next_hop    = '0;
      hit           = -1;
      case (r.kind)
         iflr_pkg::REQ_WR_ROUTE: begin
            rt_valid[r.index] = r.entry_valid;
            rt_addr[r.index]  = r.addr;
            rt_mask[r.index]  = r.mask;
            rt_iface[r.index] = r.iface;
         end
         iflr_pkg::REQ_WR_SUBNET: begin
            sn_valid[r.index] = r.entry_valid;
            sn_addr[r.index]  = r.addr;
            sn_mask[r.index]  = r.mask;
            sn_gw[r.index]    = r.gw;
            sn_iface[r.index] = r.iface;
         end
         iflr_pkg::REQ_LOOKUP: begin
            for (i = ROUTES - 1; i >= 0; i--)
               if (rt_valid[i] && ((r.dest ^ rt_addr[i]) & rt_mask[i]) == 32'd0) hit = i;
            if (hit >= 0) begin
               a.status      = iflr_pkg::ST_ROUTE;
               a.match_index = 4'(hit);
               a.out_iface   = rt_iface[hit];
               a.next_hop    = r.dest;
            end else begin
               for (i = SUBNETS - 1; i >= 0; i--)
                  if (sn_valid[i] && ((r.dest ^ sn_addr[i]) & sn_mask[i]) == 32'd0) hit = i;
               if (hit >= 0) begin
                  a.status      = iflr_pkg::ST_SUBNET;
                  a.match_index = 4'(hit);
                  a.out_iface   = sn_iface[hit];
                  a.next_hop    = r.dest;
               end else begin
                  g = first_gateway_subnet();
                  if (g >= 0) begin
                     a.status      = iflr_pkg::ST_GATEWAY;
                     a.match_index = 4'(g);
                     a.out_iface   = sn_iface[g];
                     a.next_hop    = sn_gw[g];
                  end else begin
                     a.status = iflr_pkg::ST_NONE;
                  end
               end
            end
         end
         default: begin
            if (r.use_iface) begin
               a.status    = iflr_pkg::ST_BCAST;
               a.out_iface = r.iface;
               if (sn_valid[r.index]) begin
                  a.match_index = r.index;
                  a.next_hop    = sn_addr[r.index] | ~sn_mask[r.index];
               end else begin
                  a.next_hop = iflr_pkg::ALL_ONES;
               end
            end else begin
               g = first_gateway_subnet();
               if (g >= 0) begin
                  a.status      = iflr_pkg::ST_BCAST;
                  a.match_index = 4'(g);
                  a.out_iface   = sn_iface[g];
                  a.next_hop    = iflr_pkg::ALL_ONES;
               end else begin
                  a.status = iflr_pkg::ST_NONE;
               end
            end
         end
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      route_req_type    r;
      route_answer_type e;
      int               i;
      if (reset) begin
         for (i = 0; i < ROUTES; i++) rt_valid[i] = 1'b0;
         for (i = 0; i < SUBNETS; i++) sn_valid[i] = 1'b0;
         expected_answers.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            r.kind        = iflr_pkg::req_kind_type'(req_tuser);
            r.index       = req_tdata[3:0];
            r.dest        = req_tdata[35:4];
            r.addr        = req_tdata[67:36];
            r.mask        = req_tdata[99:68];
            r.gw          = req_tdata[131:100];
            r.iface       = req_tdata[135:132];
            r.entry_valid = req_tdata[136];
            r.use_iface   = req_tdata[137];
            expected_answers.push_back(predict_answer(r));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp++;
            seen_mask = seen_mask | (6'b1 << rsp_tuser);
            if (expected_answers.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected response: status %0d index %0d iface %0d hop %h",
                           rsp_tuser, rsp_tdata[3:0], rsp_tdata[7:4], rsp_tdata[39:8]);
            end else begin
               e = expected_answers.pop_front();
               if (rsp_tuser !== e.status || rsp_tdata[3:0] !== e.match_index ||
                   rsp_tdata[7:4] !== e.out_iface || rsp_tdata[39:8] !== e.next_hop) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("mismatch on response %0d: expected status %0d index %0d %s",
                              seen_rsp, e.status, e.match_index, "(see next line)");
                     $display("   expected iface %0d hop %h, got status %0d index %0d",
                              e.out_iface, e.next_hop, rsp_tuser, rsp_tdata[3:0]);
                     $display("   got iface %0d hop %h", rsp_tdata[7:4], rsp_tdata[39:8]);
                  end
               end
            end
         end
      end
      fail_count  <= fails;
      pending     <= expected_answers.size();
      checked     <= seen_rsp;
      status_seen <= seen_mask;
   end

endmodule

// File: dv/ipv4_first_match_route_lookup_test.sv
// testbench top for the route lookup: stimulus, flow control, timeout and verdict
module ipv4_first_match_route_lookup_test;

   localparam int RANDOM_ITEMS = 600;     // random requests, table flushes come on top
   localparam int FLUSH_EVERY  = 150;     // random requests between table flushes
   localparam int CYCLE_LIMIT  = 400000;  // far above the slowest correct run
   localparam int DRAIN_CYCLES = 40;      // quiet time after the drain, longer than the pipeline latency
   localparam int HOLD_CYCLES  = 120;     // long output stall, fills the cell row
   localparam int HOLD_AT      = 280;     // request count that arms the long stall

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = iflr_pkg::REQ_WR_ROUTE;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;

   int           fail_count;
   int           pending;
   int           checked;
   logic [5:0]   status_seen;

   int           items_sent     = 0;
   int           burst_left     = 0;
   int           cycle_count    = 0;
   bit           long_hold_done = 1'b0;

   // stimulus-side copy of written addresses and masks, only used to aim lookups
   // at existing entries; indexes 0-15 are routes, 16-31 subnets
   logic [31:0]  aim_addr[32];
   logic [31:0]  aim_mask[32];

   ipv4_first_match_route_lookup u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   route_lookup_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .status_seen (status_seen)
   );

   initial forever #5 clock = ~clock;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still expected", cycle_count, pending);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // offer one request transaction and hold it until the handshake completes;
   // afterwards the burst counter may insert an idle gap
   task automatic send_request(input iflr_pkg::req_kind_type kind, input logic [3:0] idx,
                               input logic [31:0] dest, input logic [31:0] addr,
                               input logic [31:0] mask, input logic [31:0] gw,
                               input logic [3:0] ifc, input logic ev, input logic ui);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      // pad, use_iface, entry_valid, iface_id, gateway_ip, net_mask, net_addr, dest_ip, entry_index
      req_tdata  <= {6'b0, ui, ev, ifc, gw, mask, addr, dest, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         // a quarter of the bursts run straight into the next one
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // unused fields of each request carry random noise
   task automatic write_route(input logic [3:0] idx, input logic [31:0] addr,
                              input logic [31:0] mask, input logic [3:0] ifc, input logic ev);
      aim_addr[idx] = addr;
      aim_mask[idx] = mask;
      send_request(iflr_pkg::REQ_WR_ROUTE, idx, $urandom, addr, mask, $urandom, ifc, ev,
                   1'($urandom_range(0, 1)));
   endtask

   task automatic write_subnet(input logic [3:0] idx, input logic [31:0] addr,
                               input logic [31:0] mask, input logic [31:0] gw,
                               input logic [3:0] ifc, input logic ev);
      aim_addr[16 + idx] = addr;
      aim_mask[16 + idx] = mask;
      send_request(iflr_pkg::REQ_WR_SUBNET, idx, $urandom, addr, mask, gw, ifc, ev,
                   1'($urandom_range(0, 1)));
   endtask

   task automatic lookup(input logic [31:0] dest);
      send_request(iflr_pkg::REQ_LOOKUP, 4'($urandom_range(0, 15)), dest, $urandom, $urandom,
                   $urandom, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
   endtask

   task automatic broadcast(input logic ui, input logic [3:0] idx, input logic [3:0] ifc);
      send_request(iflr_pkg::REQ_BCAST, idx, $urandom, $urandom, $urandom, $urandom, ifc,
                   1'($urandom_range(0, 1)), ui);
   endtask

   // sender goes quiet until every expected response has been taken
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // mostly prefix masks, now and then empty, full or arbitrary bit patterns
   function automatic logic [31:0] random_mask();
      int sel;
      sel = $urandom_range(0, 39);
      case (sel)
         0:       return 32'd0;
         1, 2:    return 32'hFFFF_FFFF;
         3, 4, 5: return $urandom;
         default: return 32'hFFFF_FFFF << (32 - $urandom_range(8, 31));
      endcase
   endfunction

   // most lookups land inside a written entry, the rest anywhere
   function automatic logic [31:0] random_dest();
      int sel;
      int e;
      sel = $urandom_range(0, 19);
      e   = $urandom_range(0, 31);
      if (sel == 0) return 32'd0;
      if (sel == 1) return 32'hFFFF_FFFF;
      if (sel < 13) return (aim_addr[e] & aim_mask[e]) | ($urandom & ~aim_mask[e]);
      return $urandom;
   endfunction

   // receiver: random stall pattern that changes its character every so often,
   // plus one long hold-off while the sender keeps offering
   initial begin
      int mode;
      int left;
      left = 0;
      mode = 0;
      forever begin
         @(posedge clock);
         if (!long_hold_done && items_sent >= HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 200);
         end
         left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 9) == 0);
            default: rsp_tready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // stimulus
   initial begin
      int n;
      int e;
      int sel;
      for (e = 0; e < 32; e++) begin
         aim_addr[e] = '0;
         aim_mask[e] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty tables, then priority, removal, fallback and broadcast corners
      lookup(32'h0000_0000);                                   // nothing valid: no route
      broadcast(1'b0, 4'd0, 4'd0);                             // no gateway subnet: no route
      broadcast(1'b1, 4'd15, 4'd15);                           // invalid subnet: all ones
      write_route(4'd0, 32'h0A00_0000, 32'hFF00_0000, 4'd1, 1'b1);
      write_route(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1);
      lookup(32'h0A12_3456);                                   // route 0
      lookup(32'hFFFF_FFFF);                                   // host route in last slot
      write_route(4'd1, 32'h0A00_0000, 32'hFFFF_0000, 4'd9, 1'b1);
      lookup(32'h0A00_0001);                                   // both match, lowest index wins
      write_route(4'd0, 32'h0A00_0000, 32'hFF00_0000, 4'd1, 1'b0);
      lookup(32'h0A00_0001);                                   // route 0 removed, route 1 now
      write_subnet(4'd0, 32'hC0A8_0100, 32'hFFFF_FF00, 32'd0, 4'd2, 1'b1);
      write_subnet(4'd15, 32'd0, 32'd0, 32'd0, 4'd14, 1'b1);   // catch-all subnet
      lookup(32'h0102_0304);                                   // subnet 15
      lookup(32'hC0A8_01FF);                                   // subnet 0
      write_subnet(4'd15, 32'd0, 32'd0, 32'h0A0A_0A0A, 4'd14, 1'b0);  // removed, gateway ignored
      lookup(32'h0102_0304);                                   // no route again
      write_subnet(4'd3, 32'hAC10_0000, 32'hFFF0_0000, 32'hAC10_0001, 4'd4, 1'b1);
      lookup(32'h0808_0808);                                   // gateway fallback via subnet 3
      broadcast(1'b1, 4'd0, 4'd7);                             // directed broadcast of subnet 0
      broadcast(1'b0, 4'd9, 4'd0);                             // gateway subnet, all ones
      broadcast(1'b1, 4'd5, 4'd11);                            // invalid subnet index
      write_subnet(4'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 1'b1);
      lookup(32'h0000_0000);                                   // subnet 1
      broadcast(1'b0, 4'd0, 4'd0);                             // lower gateway subnet now 1

      // random part in epochs: each starts from a drained block and flushed tables
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % FLUSH_EVERY == 0) begin
            wait_idle();
            for (e = 0; e < 16; e++) begin
               write_route(4'(e), $urandom, random_mask(), 4'($urandom_range(0, 15)), 1'b0);
               write_subnet(4'(e), $urandom, random_mask(), $urandom,
                            4'($urandom_range(0, 15)), 1'b0);
            end
         end
         sel = $urandom_range(0, 99);
         if (sel < 15)
            write_route(4'($urandom_range(0, 15)), $urandom, random_mask(),
                        4'($urandom_range(0, 15)), $urandom_range(0, 3) != 0);
         else if (sel < 30)
            write_subnet(4'($urandom_range(0, 15)), $urandom, random_mask(),
                         ($urandom_range(0, 1) != 0) ? $urandom : 32'd0,
                         4'($urandom_range(0, 15)), $urandom_range(0, 3) != 0);
         else if (sel < 75)
            lookup(random_dest());
         else
            broadcast(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)));
      end

      // drain, then give the row time to show any stray response
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d request transactions and %0d checked responses in %0d cycles",
               items_sent, checked, cycle_count);
      $display("response codes seen (bit per code, write done lowest): %b, %0d failures",
               status_seen, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: ipv4_first_match_route_lookup.f
hdl/iflr_pkg.sv
hdl/iflr_cell.sv
hdl/ipv4_first_match_route_lookup.sv
dv/route_lookup_checker.sv
dv/ipv4_first_match_route_lookup_test.sv
